// ===== sv/qvr_pkg.sv =====
package qvr_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 14;

    // first product: 16x16 terms, three-term sums plus headroom for the negate
    localparam int PROD1_W = 2 * DATA_W;
    localparam int SUM1_W  = PROD1_W + 2;
    localparam int T_W     = SUM1_W - FRAC_BITS;

    // second product: T_W x DATA_W terms, four-term sums
    localparam int PROD2_W = T_W + DATA_W;
    localparam int SUM2_W  = PROD2_W + 2;
    localparam int SHR_W   = SUM2_W - FRAC_BITS;

    localparam int N_TERMS1 = 12;
    localparam int N_TERMS2 = 12;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] rot_x;
        logic signed [DATA_W-1:0] rot_y;
        logic signed [DATA_W-1:0] rot_z;
    } t_res;

    typedef struct packed {
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } t_quat;

    // t = q * (0; v), carried with q to the second product
    typedef struct packed {
        t_quat                 q;
        logic signed [T_W-1:0] tx;
        logic signed [T_W-1:0] ty;
        logic signed [T_W-1:0] tz;
        logic signed [T_W-1:0] ts;
    } t_mid;

endpackage

// ===== sv/qvr_left_prod.sv =====
module qvr_left_prod (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  qvr_pkg::t_req i_req,
    output logic          o_valid,
    output qvr_pkg::t_mid o_mid
);
    import qvr_pkg::*;

    logic                       r_v1;
    logic signed [PROD1_W-1:0]  r_p1 [N_TERMS1];
    logic signed [PROD1_W-1:0]  n_p1 [N_TERMS1];
    t_quat                      r_q1;
    logic                       r_v2;
    t_mid                       r_mid;
    t_mid                       n_mid;
    logic signed [SUM1_W-1:0]   sum_x;
    logic signed [SUM1_W-1:0]   sum_y;
    logic signed [SUM1_W-1:0]   sum_z;
    logic signed [SUM1_W-1:0]   sum_s;

    // stage 1: twelve partial products
    always_comb begin
        n_p1[0]  = PROD1_W'(i_req.quat_w * i_req.vec_x);
        n_p1[1]  = PROD1_W'(i_req.quat_y * i_req.vec_z);
        n_p1[2]  = PROD1_W'(i_req.quat_z * i_req.vec_y);
        n_p1[3]  = PROD1_W'(i_req.quat_w * i_req.vec_y);
        n_p1[4]  = PROD1_W'(i_req.quat_z * i_req.vec_x);
        n_p1[5]  = PROD1_W'(i_req.quat_x * i_req.vec_z);
        n_p1[6]  = PROD1_W'(i_req.quat_w * i_req.vec_z);
        n_p1[7]  = PROD1_W'(i_req.quat_x * i_req.vec_y);
        n_p1[8]  = PROD1_W'(i_req.quat_y * i_req.vec_x);
        n_p1[9]  = PROD1_W'(i_req.quat_x * i_req.vec_x);
        n_p1[10] = PROD1_W'(i_req.quat_y * i_req.vec_y);
        n_p1[11] = PROD1_W'(i_req.quat_z * i_req.vec_z);
    end

    // stage 2: sums, floor shift
    always_comb begin
        sum_x = SUM1_W'(r_p1[0]) + SUM1_W'(r_p1[1]) - SUM1_W'(r_p1[2]);
        sum_y = SUM1_W'(r_p1[3]) + SUM1_W'(r_p1[4]) - SUM1_W'(r_p1[5]);
        sum_z = SUM1_W'(r_p1[6]) + SUM1_W'(r_p1[7]) - SUM1_W'(r_p1[8]);
        sum_s = -(SUM1_W'(r_p1[9]) + SUM1_W'(r_p1[10]) + SUM1_W'(r_p1[11]));
        n_mid.q  = r_q1;
        n_mid.tx = T_W'(sum_x >>> FRAC_BITS);
        n_mid.ty = T_W'(sum_y >>> FRAC_BITS);
        n_mid.tz = T_W'(sum_z >>> FRAC_BITS);
        n_mid.ts = T_W'(sum_s >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1    <= n_p1;
        r_q1.w  <= i_req.quat_w;
        r_q1.x  <= i_req.quat_x;
        r_q1.y  <= i_req.quat_y;
        r_q1.z  <= i_req.quat_z;
        r_mid   <= n_mid;
    end

    assign o_valid = r_v2;
    assign o_mid   = r_mid;

endmodule

// ===== sv/qvr_right_prod.sv =====
module qvr_right_prod (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  qvr_pkg::t_mid i_mid,
    output logic          o_valid,
    output qvr_pkg::t_res o_res
);
    import qvr_pkg::*;

    localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'((1 <<< (DATA_W - 1)) - 1);
    localparam logic signed [SHR_W-1:0] SAT_MIN = -SHR_W'(1 <<< (DATA_W - 1));

    logic                       r_v3;
    logic signed [PROD2_W-1:0]  r_p2 [N_TERMS2];
    logic signed [PROD2_W-1:0]  n_p2 [N_TERMS2];
    logic                       r_v4;
    t_res                       r_res;
    t_res                       n_res;
    logic signed [SUM2_W-1:0]   sum_x;
    logic signed [SUM2_W-1:0]   sum_y;
    logic signed [SUM2_W-1:0]   sum_z;

    function automatic logic signed [DATA_W-1:0] sat(input logic signed [SHR_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = DATA_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r = DATA_W'(SAT_MIN);
        end else begin
            r = DATA_W'(v);
        end
        return r;
    endfunction

    // stage 3: t * conj(q) partial products
    always_comb begin
        n_p2[0]  = PROD2_W'(i_mid.tx * i_mid.q.w);
        n_p2[1]  = PROD2_W'(i_mid.q.x * i_mid.ts);
        n_p2[2]  = PROD2_W'(i_mid.ty * i_mid.q.z);
        n_p2[3]  = PROD2_W'(i_mid.tz * i_mid.q.y);
        n_p2[4]  = PROD2_W'(i_mid.ty * i_mid.q.w);
        n_p2[5]  = PROD2_W'(i_mid.q.y * i_mid.ts);
        n_p2[6]  = PROD2_W'(i_mid.tz * i_mid.q.x);
        n_p2[7]  = PROD2_W'(i_mid.tx * i_mid.q.z);
        n_p2[8]  = PROD2_W'(i_mid.tz * i_mid.q.w);
        n_p2[9]  = PROD2_W'(i_mid.q.z * i_mid.ts);
        n_p2[10] = PROD2_W'(i_mid.tx * i_mid.q.y);
        n_p2[11] = PROD2_W'(i_mid.ty * i_mid.q.x);
    end

    // stage 4: four-term sums, floor shift, saturate
    always_comb begin
        sum_x = SUM2_W'(r_p2[0]) - SUM2_W'(r_p2[1]) - SUM2_W'(r_p2[2]) + SUM2_W'(r_p2[3]);
        sum_y = SUM2_W'(r_p2[4]) - SUM2_W'(r_p2[5]) - SUM2_W'(r_p2[6]) + SUM2_W'(r_p2[7]);
        sum_z = SUM2_W'(r_p2[8]) - SUM2_W'(r_p2[9]) - SUM2_W'(r_p2[10]) + SUM2_W'(r_p2[11]);
        n_res.rot_x = sat(SHR_W'(sum_x >>> FRAC_BITS));
        n_res.rot_y = sat(SHR_W'(sum_y >>> FRAC_BITS));
        n_res.rot_z = sat(SHR_W'(sum_z >>> FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2  <= n_p2;
        r_res <= n_res;
    end

    assign o_valid = r_v4;
    assign o_res   = r_res;

endmodule

// ===== sv/quaternion_vector_rotate_unit.sv =====
// Rotates a 16-bit vector by a Q1.14 quaternion, q * (0; v) * conj(q), with
// floor rounding after each Hamilton product and saturation of the result to
// 16 bits; a non-unit quaternion scales the result by |q|^2. A request is taken
// on any cycle with start high and busy low, one per cycle, and its result
// shows on o_res with o_strobe for one cycle once it has passed the four-stage
// pipeline (r_p1, r_mid, r_p2, r_res): a multiplier row and an adder row for
// each of the two products. busy is high only during reset and the cycle
// after; the result side cannot stall and must take each strobe as it comes.
module quaternion_vector_rotate_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  qvr_pkg::t_req i_req,
    output logic          o_strobe,
    output qvr_pkg::t_res o_res
);
    import qvr_pkg::*;

    logic r_rdy;
    logic accept;
    logic mid_valid;
    t_mid mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign busy   = ~r_rdy;
    assign accept = start & r_rdy;

    qvr_left_prod u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_req   (i_req),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    qvr_right_prod u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .i_mid   (mid),
        .o_valid (o_strobe),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_req_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_strobe)
        else $error("request did not produce a result after 4 cycles");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 4))
        else $error("result strobe without a matching request");

    a_zero_quat_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.quat_w == '0 && i_req.quat_x == '0 && i_req.quat_y == '0
         && i_req.quat_z == '0) |-> ##4 (o_res == '0))
        else $error("zero quaternion gave a nonzero result");

    a_busy_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");
`endif

endmodule

// ===== test/quaternion_vector_rotate_checker.sv =====
module quaternion_vector_rotate_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  qvr_pkg::t_req i_req,
    input  logic          o_strobe,
    input  qvr_pkg::t_res o_res,
    output int            mismatch_count,
    output int            rotations_outstanding
);
    import qvr_pkg::*;

    t_res rotation_queue[$];

    function automatic logic signed [DATA_W-1:0] clamp_word(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DATA_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end
        if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    // q * (0; v) * conj(q), floor shift after each product, 64-bit accumulators
    function automatic t_res predict_rotation(t_req r);
        longint w, x, y, z, vx, vy, vz;
        longint tx, ty, tz, ts;
        t_res   p;
        w  = longint'(r.quat_w);
        x  = longint'(r.quat_x);
        y  = longint'(r.quat_y);
        z  = longint'(r.quat_z);
        vx = longint'(r.vec_x);
        vy = longint'(r.vec_y);
        vz = longint'(r.vec_z);
        tx = (w * vx + y * vz - z * vy) >>> FRAC_BITS;
        ty = (w * vy + z * vx - x * vz) >>> FRAC_BITS;
        tz = (w * vz + x * vy - y * vx) >>> FRAC_BITS;
        ts = (-(x * vx + y * vy + z * vz)) >>> FRAC_BITS;
        p.rot_x = clamp_word((tx * w - x * ts - ty * z + tz * y) >>> FRAC_BITS);
        p.rot_y = clamp_word((ty * w - y * ts - tz * x + tx * z) >>> FRAC_BITS);
        p.rot_z = clamp_word((tz * w - z * ts - tx * y + ty * x) >>> FRAC_BITS);
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (o_strobe) begin
            if (rotation_queue.size() == 0) begin
                report_mismatch($sformatf("result (%0d %0d %0d) with no request pending",
                                          o_res.rot_x, o_res.rot_y, o_res.rot_z));
            end else begin
                want = rotation_queue.pop_front();
                if (o_res.rot_x !== want.rot_x)
                    report_mismatch($sformatf("rot_x got %0d, expected %0d",
                                              o_res.rot_x, want.rot_x));
                if (o_res.rot_y !== want.rot_y)
                    report_mismatch($sformatf("rot_y got %0d, expected %0d",
                                              o_res.rot_y, want.rot_y));
                if (o_res.rot_z !== want.rot_z)
                    report_mismatch($sformatf("rot_z got %0d, expected %0d",
                                              o_res.rot_z, want.rot_z));
            end
        end
        if (i_rst_n && start && !busy) begin
            rotation_queue.push_back(predict_rotation(i_req));
        end
        rotations_outstanding <= rotation_queue.size();
    end

endmodule

// ===== test/quaternion_vector_rotate_unit_test.sv =====
module quaternion_vector_rotate_unit_test;
    import qvr_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RAND_ITEMS = 1850;
    localparam int Q_ONE      = 1 << FRAC_BITS;
    localparam int Q_COS45    = 11585;   // cos(pi/4) in Q1.14
    localparam int W_MAX      = 32767;
    localparam int W_MIN      = -32768;

    logic i_clk;
    logic i_rst_n  = 1'b0;
    logic start    = 1'b0;
    logic busy;
    t_req i_req    = '0;
    logic o_strobe;
    t_res o_res;

    int mismatch_count;
    int rotations_outstanding;
    bit idle_enable = 1'b1;

    quaternion_vector_rotate_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    quaternion_vector_rotate_checker rot_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_req                (i_req),
        .o_strobe             (o_strobe),
        .o_res                (o_res),
        .mismatch_count       (mismatch_count),
        .rotations_outstanding(rotations_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(2 * CLK_HALF * 300000);
        $display("quaternion_vector_rotate_unit regression: fail");
        $finish;
    end

    function automatic t_req make_request(int w, int x, int y, int z,
                                          int vx, int vy, int vz);
        t_req r;
        r.quat_w = w[DATA_W-1:0];
        r.quat_x = x[DATA_W-1:0];
        r.quat_y = y[DATA_W-1:0];
        r.quat_z = z[DATA_W-1:0];
        r.vec_x  = vx[DATA_W-1:0];
        r.vec_y  = vy[DATA_W-1:0];
        r.vec_z  = vz[DATA_W-1:0];
        return r;
    endfunction

    function automatic int rand_signed(int mag);
        return int'($urandom_range(2 * mag)) - mag;
    endfunction

    // half unit quaternions, the rest raw or small
    function automatic t_req random_request();
        t_req r;
        real  a, b, c, d, n;
        int   kind;
        kind = $urandom_range(99);
        r = t_req'({$urandom, $urandom, $urandom, $urandom});
        if (kind < 50) begin
            a = real'(rand_signed(10000));
            b = real'(rand_signed(10000));
            c = real'(rand_signed(10000));
            d = real'(rand_signed(10000));
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) begin
                a = 1.0;
                n = 1.0;
            end
            r.quat_w = DATA_W'($rtoi(a / n * Q_ONE));
            r.quat_x = DATA_W'($rtoi(b / n * Q_ONE));
            r.quat_y = DATA_W'($rtoi(c / n * Q_ONE));
            r.quat_z = DATA_W'($rtoi(d / n * Q_ONE));
            if (kind < 20) begin
                r.vec_x = DATA_W'(rand_signed(200));
                r.vec_y = DATA_W'(rand_signed(200));
                r.vec_z = DATA_W'(rand_signed(200));
            end
        end else if (kind < 75) begin
            r.quat_w = DATA_W'(rand_signed(Q_COS45));
            r.quat_x = DATA_W'(rand_signed(Q_COS45));
            r.quat_y = DATA_W'(rand_signed(Q_COS45));
            r.quat_z = DATA_W'(rand_signed(Q_COS45));
        end
        return r;
    endfunction

    task automatic idle_gap();
        while (idle_enable && $urandom_range(99) < 33) begin
            start <= 1'b0;
            i_req <= t_req'({$urandom, $urandom, $urandom, $urandom});
            @(posedge i_clk);
        end
    endtask

    task automatic send_request(t_req r);
        idle_gap();
        start <= 1'b1;
        i_req <= r;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (rotations_outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        t_req directed[$];

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_request(0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(Q_ONE, 0, 0, 0, W_MAX, W_MIN, 1));
        directed.push_back(make_request(Q_ONE, 0, 0, 0, W_MIN, W_MAX, -1));
        // quarter turns about each axis
        directed.push_back(make_request(Q_COS45, Q_COS45, 0, 0, 100, 200, 300));
        directed.push_back(make_request(Q_COS45, 0, Q_COS45, 0, 100, 200, 300));
        directed.push_back(make_request(Q_COS45, 0, 0, Q_COS45, 100, 200, 300));
        directed.push_back(make_request(Q_COS45, 0, 0, -Q_COS45, -1000, 5, 7));
        // half turns and a negated identity
        directed.push_back(make_request(0, Q_ONE, 0, 0, 1234, -4321, 77));
        directed.push_back(make_request(0, 0, 0, -Q_ONE, W_MAX, W_MAX, W_MAX));
        directed.push_back(make_request(-Q_ONE, 0, 0, 0, 5, -6, 7));
        // non-unit q, saturation both ways
        directed.push_back(make_request(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        directed.push_back(make_request(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
        directed.push_back(make_request(W_MAX, W_MIN, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN));
        directed.push_back(make_request(W_MIN, W_MAX, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX));
        directed.push_back(make_request(2 * Q_ONE - 1, 0, 0, 0, 20000, -20000, 9000));
        directed.push_back(make_request(0, W_MIN, 0, 0, W_MIN, 0, 0));
        // floor rounding on small and negative terms
        directed.push_back(make_request(1, 1, 1, 1, 1, 1, 1));
        directed.push_back(make_request(-1, -1, -1, -1, -1, -1, -1));
        directed.push_back(make_request(3, -2, 5, -7, -1, -1, -1));
        directed.push_back(make_request(Q_ONE - 1, 1, -1, 1, -3, 2, -1));
        directed.push_back(make_request(Q_COS45, -Q_COS45, 0, 0, W_MIN, W_MIN, W_MIN));
        directed.push_back(make_request(8192, 8192, 8192, 8192, W_MAX, W_MIN, 0));

        foreach (directed[k]) send_request(directed[k]);

        // hold off until the pipe is empty
        drain();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            idle_enable = !(n >= 600 && n < 1000);
            if (n == 1300) drain();
            send_request(random_request());
        end

        drain();
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && rotations_outstanding == 0) begin
            $display("quaternion_vector_rotate_unit regression: pass");
        end else begin
            $display("quaternion_vector_rotate_unit regression: fail");
        end
        $finish;
    end

endmodule
